/* hdl/mtdc_pkg.sv */
// Shared types, codes and constants of the monochrome text cursor controller.
package mtdc_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int SCREEN_COLUMNS = 80;

    // Bus operations carried by one input transaction.
    typedef enum logic [2:0] {
        OP_INDEX_WR  = 3'd0,
        OP_DATA_WR   = 3'd1,
        OP_DATA_RD   = 3'd2,
        OP_STATUS_RD = 3'd3,
        OP_MEM_WR    = 3'd4,
        OP_MEM_RD    = 3'd5,
        OP_TICK      = 3'd6
    } t_opcode;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_BUS     = 2'd0,
        KIND_RESTORE = 2'd1,
        KIND_DRAW    = 2'd2
    } t_kind;

    // CRTC register indexes.
    localparam logic [4:0] CRTC_CUR_START = 5'h0a;
    localparam logic [4:0] CRTC_CUR_END   = 5'h0b;
    localparam logic [4:0] CRTC_POS_HI    = 5'h0e;
    localparam logic [4:0] CRTC_POS_LO    = 5'h0f;

    localparam logic [7:0] STATUS_RESET  = 8'hf0;
    localparam logic [7:0] STATUS_TOGGLE = 8'h09;
    localparam logic [7:0] READ_UNKNOWN  = 8'hff;

    // 80 columns by 25 rows.
    localparam logic [11:0] SCREEN_CELLS = 12'd2000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture input transaction
        logic exec;      // run the captured operation
        logic mem_out;   // load bus result from text memory read data
        logic rest_out;  // load restore-cell result
        logic draw_rd;   // read the cursor cell word
        logic draw_out;  // load draw-cell result
        logic clear;     // clear one text memory word
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic    out_free;
        logic    clear_done;
        t_opcode op;
        logic    tick_restore;
        logic    tick_draw;
        logic    draw_pending;
    } t_dp_status;

endpackage

/* hdl/mtdc_text_mem.sv */
// Text memory: even (character) and odd (attribute) byte banks, registered read.
module mtdc_text_mem #(
    parameter int P_WORDS = mtdc_pkg::MEM_BYTES / 2
) (
    input  logic                       i_clk,
    input  logic                       i_we_even,
    input  logic                       i_we_odd,
    input  logic [$clog2(P_WORDS)-1:0] i_waddr,
    input  logic [7:0]                 i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_WORDS)-1:0] i_raddr,
    output logic [7:0]                 o_rdata_even,
    output logic [7:0]                 o_rdata_odd
);

    logic [7:0] r_bank_even [P_WORDS];
    logic [7:0] r_bank_odd  [P_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we_even) begin
            r_bank_even[i_waddr] <= i_wdata;
        end
        if (i_we_odd) begin
            r_bank_odd[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_even <= r_bank_even[i_raddr];
            o_rdata_odd  <= r_bank_odd[i_raddr];
        end
    end

endmodule

/* hdl/mtdc_datapath.sv */
// Datapath: CRTC and status registers, cursor blink logic, text memory, result register.
module mtdc_datapath #(
    parameter int P_MEM_BYTES = mtdc_pkg::MEM_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mtdc_pkg::t_dp_cmd    i_cmd,
    output mtdc_pkg::t_dp_status o_status,
    input  logic [2:0]           i_opcode,
    input  logic [14:0]          i_mem_address,
    input  logic [7:0]           i_write_value,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [1:0]           o_result_kind,
    output logic [7:0]           o_read_data,
    output logic [4:0]           o_cell_row,
    output logic [6:0]           o_cell_column,
    output logic [7:0]           o_cell_char,
    output logic [7:0]           o_cell_attr,
    output logic [1:0]           o_cell_style,
    output logic                 o_last_result
);

    localparam int ADDR_W = $clog2(P_MEM_BYTES);
    localparam int WORD_W = ADDR_W - 1;
    localparam int WORDS  = P_MEM_BYTES / 2;

    // pos / 80 = (pos >> 4) / 5, and x / 5 = (x * 205) >> 10 for x below 1024
    localparam logic [15:0] DIV5_MUL   = 16'd205;
    localparam int          DIV5_SHIFT = 10;

    localparam logic [7:0] GLYPH_NONE  = 8'h00;
    localparam logic [7:0] GLYPH_BLOCK = 8'hdb;
    localparam logic [7:0] GLYPH_UPPER = 8'hdf;
    localparam logic [7:0] GLYPH_LOWER = 8'hdc;
    localparam logic [7:0] GLYPH_DASH  = 8'h2d;
    localparam logic [7:0] GLYPH_LINE  = 8'h5f;

    localparam logic [7:0] ATTR_FG_BG_MASK = 8'h77;
    localparam logic [7:0] ATTR_REVERSE    = 8'h70;
    localparam logic [7:0] CUR_OFF_MASK    = 8'h60;
    localparam logic [7:0] CUR_OFF_CODE    = 8'h20;

    function automatic logic [7:0] f_glyph(input logic on, input logic [4:0] s,
                                           input logic [4:0] e);
        logic [7:0] g;
        if (!on || e < s) begin
            g = GLYPH_NONE;
        end else if (s < 5'd4) begin
            g = (e > 5'd10) ? GLYPH_BLOCK : GLYPH_UPPER;
        end else if (s < 5'd10) begin
            g = (e > 5'd12) ? GLYPH_LOWER : GLYPH_DASH;
        end else begin
            g = GLYPH_LINE;
        end
        return g;
    endfunction

    function automatic logic [1:0] f_style(input logic [7:0] a);
        logic [1:0] s;
        if ((a & ATTR_FG_BG_MASK) == 8'h00) begin
            s = 2'd0;
        end else if ((a & ATTR_FG_BG_MASK) == ATTR_REVERSE) begin
            s = 2'd1;
        end else if (a[3]) begin
            s = 2'd2;
        end else begin
            s = 2'd3;
        end
        return s;
    endfunction

    // Input capture
    mtdc_pkg::t_opcode r_op;
    logic [14:0]       r_addr;
    logic [7:0]        r_val;

    // Architectural state
    logic [4:0]  r_crtc_index, n_crtc_index;
    logic        r_cursor_on, n_cursor_on;
    logic [4:0]  r_start_line, n_start_line;
    logic [4:0]  r_end_line, n_end_line;
    logic [11:0] r_cursor_pos, n_cursor_pos;
    logic        r_shape_dirty, n_shape_dirty;
    logic [7:0]  r_cursor_glyph, n_cursor_glyph;
    logic [3:0]  r_blink, n_blink;
    logic [7:0]  r_shown_glyph, n_shown_glyph;
    logic [11:0] r_shown_pos, n_shown_pos;
    logic [7:0]  r_status, n_status;
    logic [11:0] r_old_pos, n_old_pos;
    logic        r_do_draw, n_do_draw;
    logic [WORD_W-1:0] r_clr_cnt, n_clr_cnt;

    // Result register
    logic              r_out_valid, n_out_valid;
    mtdc_pkg::t_kind   r_kind, n_kind;
    logic [7:0]        r_read_data, n_read_data;
    logic [4:0]        r_cell_row, n_cell_row;
    logic [6:0]        r_cell_col, n_cell_col;
    logic [7:0]        r_cell_char, n_cell_char;
    logic [7:0]        r_cell_attr, n_cell_attr;
    logic [1:0]        r_cell_style, n_cell_style;
    logic              r_last, n_last;

    // Tick evaluation
    logic [7:0]  w_glyph;
    logic [3:0]  w_blink;
    logic [7:0]  w_now;
    logic        w_moved;
    logic        w_restore;
    logic        w_draw;

    // Memory ports
    logic              w_we_even;
    logic              w_we_odd;
    logic [WORD_W-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic              w_re;
    logic [WORD_W-1:0] w_raddr;
    logic [7:0]        w_rd_even;
    logic [7:0]        w_rd_odd;

    logic        w_out_free;
    logic        w_bus_op;
    logic [7:0]  w_bus_data;
    logic [11:0] w_cell_pos;
    logic [15:0] w_row_prod;
    logic [4:0]  w_row;
    logic [11:0] w_row_base;
    logic [6:0]  w_col;

    mtdc_text_mem #(
        .P_WORDS (WORDS)
    ) u_text_mem (
        .i_clk        (i_clk),
        .i_we_even    (w_we_even),
        .i_we_odd     (w_we_odd),
        .i_waddr      (w_waddr),
        .i_wdata      (w_wdata),
        .i_re         (w_re),
        .i_raddr      (w_raddr),
        .o_rdata_even (w_rd_even),
        .o_rdata_odd  (w_rd_odd)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_glyph   = r_shape_dirty ? f_glyph(r_cursor_on, r_start_line, r_end_line)
                                  : r_cursor_glyph;
        w_blink   = r_blink + 4'd1;
        w_now     = w_blink[3] ? w_glyph : GLYPH_NONE;
        w_moved   = r_cursor_pos != r_shown_pos;
        w_restore = (r_shown_glyph != GLYPH_NONE) && (r_shown_pos < mtdc_pkg::SCREEN_CELLS)
                    && ((w_now == GLYPH_NONE) || w_moved);
        w_draw    = (w_now != GLYPH_NONE) && (r_cursor_pos < mtdc_pkg::SCREEN_CELLS)
                    && ((w_now != r_shown_glyph) || w_moved);
    end

    // Memory port steering
    always_comb begin
        w_we_even = 1'b0;
        w_we_odd  = 1'b0;
        w_waddr   = r_addr[ADDR_W-1:1];
        w_wdata   = r_val;
        if (i_cmd.clear) begin
            w_we_even = 1'b1;
            w_we_odd  = 1'b1;
            w_waddr   = r_clr_cnt;
            w_wdata   = 8'h00;
        end else if (i_cmd.exec && r_op == mtdc_pkg::OP_MEM_WR) begin
            w_we_even = !r_addr[0];
            w_we_odd  = r_addr[0];
        end

        w_re    = i_cmd.draw_rd
                  || (i_cmd.exec && (r_op == mtdc_pkg::OP_MEM_RD || r_op == mtdc_pkg::OP_TICK));
        w_raddr = r_cursor_pos[WORD_W-1:0];
        if (i_cmd.exec && r_op == mtdc_pkg::OP_MEM_RD) begin
            w_raddr = r_addr[ADDR_W-1:1];
        end else if (i_cmd.exec && w_restore) begin
            w_raddr = r_shown_pos[WORD_W-1:0];
        end
    end

    // Bus read data and cell position split
    always_comb begin
        w_bus_op = 1'b0;
        case (r_op)
            mtdc_pkg::OP_INDEX_WR,
            mtdc_pkg::OP_DATA_WR,
            mtdc_pkg::OP_DATA_RD,
            mtdc_pkg::OP_STATUS_RD,
            mtdc_pkg::OP_MEM_WR: w_bus_op = 1'b1;
            default:             w_bus_op = 1'b0;
        endcase

        w_bus_data = 8'h00;
        case (r_op)
            mtdc_pkg::OP_DATA_RD: begin
                if (r_crtc_index == mtdc_pkg::CRTC_POS_HI) begin
                    w_bus_data = {4'h0, r_cursor_pos[11:8]};
                end else if (r_crtc_index == mtdc_pkg::CRTC_POS_LO) begin
                    w_bus_data = r_cursor_pos[7:0];
                end else begin
                    w_bus_data = mtdc_pkg::READ_UNKNOWN;
                end
            end
            mtdc_pkg::OP_STATUS_RD: w_bus_data = r_status ^ mtdc_pkg::STATUS_TOGGLE;
            default:                w_bus_data = 8'h00;
        endcase

        w_cell_pos = i_cmd.rest_out ? r_old_pos : r_cursor_pos;
        w_row_prod = {8'h00, w_cell_pos[11:4]} * DIV5_MUL;
        w_row      = w_row_prod[DIV5_SHIFT+4:DIV5_SHIFT];
        w_row_base = 12'(w_row * mtdc_pkg::SCREEN_COLUMNS);
        w_col      = 7'(w_cell_pos - w_row_base);
    end

    // Architectural state next values
    always_comb begin
        n_crtc_index   = r_crtc_index;
        n_cursor_on    = r_cursor_on;
        n_start_line   = r_start_line;
        n_end_line     = r_end_line;
        n_cursor_pos   = r_cursor_pos;
        n_shape_dirty  = r_shape_dirty;
        n_cursor_glyph = r_cursor_glyph;
        n_blink        = r_blink;
        n_shown_glyph  = r_shown_glyph;
        n_shown_pos    = r_shown_pos;
        n_status       = r_status;
        n_old_pos      = r_old_pos;
        n_do_draw      = r_do_draw;
        n_clr_cnt      = r_clr_cnt;

        if (i_cmd.clear) begin
            n_clr_cnt = r_clr_cnt + 1'b1;
        end

        if (i_cmd.exec) begin
            case (r_op)
                mtdc_pkg::OP_INDEX_WR: n_crtc_index = r_val[4:0];
                mtdc_pkg::OP_DATA_WR: begin
                    if (r_crtc_index == mtdc_pkg::CRTC_CUR_START) begin
                        n_cursor_on   = (r_val & CUR_OFF_MASK) != CUR_OFF_CODE;
                        n_start_line  = r_val[4:0];
                        n_shape_dirty = 1'b1;
                    end else if (r_crtc_index == mtdc_pkg::CRTC_CUR_END) begin
                        n_end_line    = r_val[4:0];
                        n_shape_dirty = 1'b1;
                    end else if (r_crtc_index == mtdc_pkg::CRTC_POS_HI) begin
                        n_cursor_pos  = {r_val[3:0], r_cursor_pos[7:0]};
                    end else if (r_crtc_index == mtdc_pkg::CRTC_POS_LO) begin
                        n_cursor_pos  = {r_cursor_pos[11:8], r_val};
                    end
                end
                mtdc_pkg::OP_STATUS_RD: n_status = r_status ^ mtdc_pkg::STATUS_TOGGLE;
                mtdc_pkg::OP_TICK: begin
                    n_cursor_glyph = w_glyph;
                    n_shape_dirty  = 1'b0;
                    n_blink        = w_blink;
                    n_shown_glyph  = w_now;
                    n_shown_pos    = r_cursor_pos;
                    n_old_pos      = r_shown_pos;
                    n_do_draw      = w_draw;
                end
                default: ;
            endcase
        end
    end

    // Result register next values
    always_comb begin
        n_out_valid  = r_out_valid && i_out_stall;
        n_kind       = r_kind;
        n_read_data  = r_read_data;
        n_cell_row   = r_cell_row;
        n_cell_col   = r_cell_col;
        n_cell_char  = r_cell_char;
        n_cell_attr  = r_cell_attr;
        n_cell_style = r_cell_style;
        n_last       = r_last;

        if ((i_cmd.exec && w_bus_op) || i_cmd.mem_out) begin
            n_out_valid  = 1'b1;
            n_kind       = mtdc_pkg::KIND_BUS;
            n_read_data  = i_cmd.mem_out ? (r_addr[0] ? w_rd_odd : w_rd_even) : w_bus_data;
            n_cell_row   = 5'd0;
            n_cell_col   = 7'd0;
            n_cell_char  = 8'h00;
            n_cell_attr  = 8'h00;
            n_cell_style = 2'd0;
            n_last       = 1'b1;
        end else if (i_cmd.rest_out || i_cmd.draw_out) begin
            n_out_valid  = 1'b1;
            n_kind       = i_cmd.rest_out ? mtdc_pkg::KIND_RESTORE : mtdc_pkg::KIND_DRAW;
            n_read_data  = 8'h00;
            n_cell_row   = w_row;
            n_cell_col   = w_col;
            n_cell_char  = i_cmd.rest_out ? w_rd_even : r_shown_glyph;
            n_cell_attr  = w_rd_odd;
            n_cell_style = f_style(w_rd_odd);
            n_last       = i_cmd.draw_out || !r_do_draw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crtc_index   <= 5'd0;
            r_cursor_on    <= 1'b0;
            r_start_line   <= 5'd0;
            r_end_line     <= 5'd0;
            r_cursor_pos   <= 12'd0;
            r_shape_dirty  <= 1'b0;
            r_cursor_glyph <= GLYPH_NONE;
            r_blink        <= 4'd0;
            r_shown_glyph  <= GLYPH_NONE;
            r_shown_pos    <= 12'd0;
            r_status       <= mtdc_pkg::STATUS_RESET;
            r_do_draw      <= 1'b0;
            r_clr_cnt      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_crtc_index   <= n_crtc_index;
            r_cursor_on    <= n_cursor_on;
            r_start_line   <= n_start_line;
            r_end_line     <= n_end_line;
            r_cursor_pos   <= n_cursor_pos;
            r_shape_dirty  <= n_shape_dirty;
            r_cursor_glyph <= n_cursor_glyph;
            r_blink        <= n_blink;
            r_shown_glyph  <= n_shown_glyph;
            r_shown_pos    <= n_shown_pos;
            r_status       <= n_status;
            r_do_draw      <= n_do_draw;
            r_clr_cnt      <= n_clr_cnt;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= mtdc_pkg::t_opcode'(i_opcode);
            r_addr <= i_mem_address;
            r_val  <= i_write_value;
        end
        r_old_pos    <= n_old_pos;
        r_kind       <= n_kind;
        r_read_data  <= n_read_data;
        r_cell_row   <= n_cell_row;
        r_cell_col   <= n_cell_col;
        r_cell_char  <= n_cell_char;
        r_cell_attr  <= n_cell_attr;
        r_cell_style <= n_cell_style;
        r_last       <= n_last;
    end

    assign o_status.out_free     = w_out_free;
    assign o_status.clear_done   = &r_clr_cnt;
    assign o_status.op           = r_op;
    assign o_status.tick_restore = w_restore;
    assign o_status.tick_draw    = w_draw;
    assign o_status.draw_pending = r_do_draw;

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_read_data   = r_read_data;
    assign o_cell_row    = r_cell_row;
    assign o_cell_column = r_cell_col;
    assign o_cell_char   = r_cell_char;
    assign o_cell_attr   = r_cell_attr;
    assign o_cell_style  = r_cell_style;
    assign o_last_result = r_last;

endmodule

/* hdl/mtdc_ctrl.sv */
// Controller: sequences memory clearing, operation execution and result loading.
module mtdc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mtdc_pkg::t_dp_status i_status,
    output mtdc_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_EXEC     = 7'b0000100,
        S_MREAD    = 7'b0001000,
        S_REST_OUT = 7'b0010000,
        S_DRAW_RD  = 7'b0100000,
        S_DRAW_OUT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign w_accept   = i_in_valid && (r_state == S_IDLE) && i_status.out_free;
    assign o_in_stall = !((r_state == S_IDLE) && i_status.out_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_status.op)
                    mtdc_pkg::OP_MEM_RD: n_state = S_MREAD;
                    mtdc_pkg::OP_TICK: begin
                        if (i_status.tick_restore) begin
                            n_state = S_REST_OUT;
                        end else if (i_status.tick_draw) begin
                            n_state = S_DRAW_OUT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_MREAD: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_REST_OUT: begin
                if (i_status.out_free) begin
                    n_state = i_status.draw_pending ? S_DRAW_RD : S_IDLE;
                end
            end
            S_DRAW_RD: n_state = S_DRAW_OUT;
            S_DRAW_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd.latch    = w_accept;
        o_cmd.exec     = r_state == S_EXEC;
        o_cmd.mem_out  = (r_state == S_MREAD) && i_status.out_free;
        o_cmd.rest_out = (r_state == S_REST_OUT) && i_status.out_free;
        o_cmd.draw_rd  = r_state == S_DRAW_RD;
        o_cmd.draw_out = (r_state == S_DRAW_OUT) && i_status.out_free;
        o_cmd.clear    = r_state == S_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/mono_text_display_cursor_ctrl_unit.sv */
// A bus access is captured, then executed into the result register; a text memory
// read adds a read state. A tick with nothing to redraw goes back to idle; else it
// loads a restore or draw result, or a restore, a cursor cell re-read and a draw.
// Transactions are taken only in idle, so one is through before the next is taken.
// Reset: synchronous, active low; then a pass clears the text memory
// (one character/attribute word per cycle) while input stays stalled.
module mono_text_display_cursor_ctrl_unit #(
    parameter int P_MEM_BYTES = mtdc_pkg::MEM_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transaction channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [14:0] i_mem_address,
    input  logic [7:0]  i_write_value,
    // result transaction channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_read_data,
    output logic [4:0]  o_cell_row,
    output logic [6:0]  o_cell_column,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attr,
    output logic [1:0]  o_cell_style,
    output logic        o_last_result
);

    // Command and status buses between controller and datapath.
    mtdc_pkg::t_dp_cmd    w_cmd;
    mtdc_pkg::t_dp_status w_status;

    // Controller: hold input stalled during clearing and until the result
    // register can take the next result; step through tick reads one cell at a time.
    mtdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: CRTC registers, blink state, banked text memory, result register.
    mtdc_datapath #(
        .P_MEM_BYTES (P_MEM_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_opcode      (i_opcode),
        .i_mem_address (i_mem_address),
        .i_write_value (i_write_value),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_result_kind (o_result_kind),
        .o_read_data   (o_read_data),
        .o_cell_row    (o_cell_row),
        .o_cell_column (o_cell_column),
        .o_cell_char   (o_cell_char),
        .o_cell_attr   (o_cell_attr),
        .o_cell_style  (o_cell_style),
        .o_last_result (o_last_result)
    );

    // An accepted transaction always finds the result register empty next cycle.
    a_accept_empties_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !o_out_valid)
        else $error("result register busy after accept");

    // Cell results always land on the visible screen.
    a_cell_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind != mtdc_pkg::KIND_BUS))
        |-> (o_cell_row < 5'd25) && (o_cell_column < 7'd80))
        else $error("cell result off screen");

    // A bus access always produces exactly one, final, result.
    a_bus_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == mtdc_pkg::KIND_BUS)) |-> o_last_result)
        else $error("bus result not marked last");

    // No transaction is taken while the memory clearing pass runs.
    a_stall_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |-> o_in_stall)
        else $error("input accepted during clear");

endmodule

/* tb/sv/mtdc_screen_model_pkg.sv */
// Predictor and result scoreboard for the monochrome text cursor controller.
package mtdc_screen_model_pkg;

    import mtdc_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic [1:0] STYLE_INVISIBLE = 2'd0;
    localparam logic [1:0] STYLE_REVERSE   = 2'd1;
    localparam logic [1:0] STYLE_BOLD      = 2'd2;
    localparam logic [1:0] STYLE_NORMAL    = 2'd3;

    localparam logic [7:0] ATTR_VISIBLE_MASK = 8'h77;
    localparam logic [7:0] ATTR_REVERSE      = 8'h70;
    localparam logic [7:0] CURSOR_OFF_MASK   = 8'h60;
    localparam logic [7:0] CURSOR_OFF_CODE   = 8'h20;

    localparam logic [7:0] GLYPH_NONE        = 8'h00;
    localparam logic [7:0] GLYPH_BLOCK       = 8'hdb;
    localparam logic [7:0] GLYPH_TOP_HALF    = 8'hdf;
    localparam logic [7:0] GLYPH_BOTTOM_HALF = 8'hdc;
    localparam logic [7:0] GLYPH_DASH        = 8'h2d;
    localparam logic [7:0] GLYPH_UNDERSCORE  = 8'h5f;

    typedef struct {
        t_kind      kind;
        logic [7:0] rd;
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [1:0] style;
        logic       last;
    } mtdc_answer_t;

    class mtdc_screen_model;

        bit [4:0]     crtc_idx;
        bit           cursor_en;
        bit [4:0]     start_ln;
        bit [4:0]     end_ln;
        bit [11:0]    cur_pos;
        bit           shape_chg;
        bit [7:0]     glyph;
        bit [3:0]     blink;
        bit [7:0]     shown_gl;
        bit [11:0]    shown_pos;
        bit [7:0]     status;
        bit [7:0]     vram [MEM_BYTES];
        mtdc_answer_t answers [$];
        int           mismatches;

        function new();
            status = STATUS_RESET;
        endfunction

        function bit [1:0] style_of(bit [7:0] attr);
            if ((attr & ATTR_VISIBLE_MASK) == 8'h00) return STYLE_INVISIBLE;
            if ((attr & ATTR_VISIBLE_MASK) == ATTR_REVERSE) return STYLE_REVERSE;
            if (attr[3]) return STYLE_BOLD;
            return STYLE_NORMAL;
        endfunction

        function bit [7:0] shape_glyph();
            if (!cursor_en || end_ln < start_ln) return GLYPH_NONE;
            if (start_ln < 4) return (end_ln > 10) ? GLYPH_BLOCK : GLYPH_TOP_HALF;
            if (start_ln < 10) return (end_ln > 12) ? GLYPH_BOTTOM_HALF : GLYPH_DASH;
            return GLYPH_UNDERSCORE;
        endfunction

        function mtdc_answer_t cell_answer(t_kind kind, bit [11:0] pos, bit [7:0] ch, bit last);
            mtdc_answer_t a;
            bit [7:0] attr;
            attr    = vram[{pos[10:0], 1'b1}];
            a.kind  = kind;
            a.rd    = '0;
            a.row   = 5'(pos / SCREEN_COLUMNS);
            a.col   = 7'(pos % SCREEN_COLUMNS);
            a.ch    = ch;
            a.attr  = attr;
            a.style = style_of(attr);
            a.last  = last;
            return a;
        endfunction

        function void advance_tick();
            bit [7:0] now_gl;
            bit       restore;
            bit       draw;
            if (shape_chg) begin
                glyph     = shape_glyph();
                shape_chg = 1'b0;
            end
            blink   = blink + 4'd1;
            now_gl  = blink[3] ? glyph : GLYPH_NONE;
            restore = shown_gl != GLYPH_NONE && shown_pos < SCREEN_CELLS &&
                      (now_gl == GLYPH_NONE || cur_pos != shown_pos);
            draw    = now_gl != GLYPH_NONE && cur_pos < SCREEN_CELLS &&
                      (now_gl != shown_gl || cur_pos != shown_pos);
            if (restore) begin
                answers.push_back(cell_answer(KIND_RESTORE, shown_pos,
                                              vram[{shown_pos[10:0], 1'b0}], !draw));
            end
            if (draw) begin
                answers.push_back(cell_answer(KIND_DRAW, cur_pos, now_gl, 1'b1));
            end
            shown_gl  = now_gl;
            shown_pos = cur_pos;
        endfunction

        // Note one accepted input transaction and queue what it must produce.
        function void take_op(logic [2:0] op, logic [14:0] addr, logic [7:0] val);
            bit [7:0]     data;
            mtdc_answer_t a;
            data = 8'h00;
            case (op)
                OP_INDEX_WR: crtc_idx = val[4:0];
                OP_DATA_WR: begin
                    if (crtc_idx == CRTC_CUR_START) begin
                        cursor_en = (val & CURSOR_OFF_MASK) != CURSOR_OFF_CODE;
                        start_ln  = val[4:0];
                        shape_chg = 1'b1;
                    end else if (crtc_idx == CRTC_CUR_END) begin
                        end_ln    = val[4:0];
                        shape_chg = 1'b1;
                    end else if (crtc_idx == CRTC_POS_HI) begin
                        cur_pos[11:8] = val[3:0];
                    end else if (crtc_idx == CRTC_POS_LO) begin
                        cur_pos[7:0] = val;
                    end
                end
                OP_DATA_RD: begin
                    if (crtc_idx == CRTC_POS_HI) data = {4'h0, cur_pos[11:8]};
                    else if (crtc_idx == CRTC_POS_LO) data = cur_pos[7:0];
                    else data = READ_UNKNOWN;
                end
                OP_STATUS_RD: begin
                    status = status ^ STATUS_TOGGLE;
                    data   = status;
                end
                OP_MEM_WR: vram[addr[11:0]] = val;
                OP_MEM_RD: data = vram[addr[11:0]];
                OP_TICK: begin
                    advance_tick();
                    return;
                end
                default: return;
            endcase
            a.kind  = KIND_BUS;
            a.rd    = data;
            a.row   = '0;
            a.col   = '0;
            a.ch    = '0;
            a.attr  = '0;
            a.style = '0;
            a.last  = 1'b1;
            answers.push_back(a);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        // Check one accepted result transaction against the oldest pending answer.
        function void match_result(mtdc_answer_t got);
            mtdc_answer_t want;
            if (answers.size() == 0) begin
                $error("result_kind: expected nothing, got %0h", got.kind);
                mismatches++;
                return;
            end
            want = answers.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("read_data", want.rd, got.rd);
            compare_field("cell_row", want.row, got.row);
            compare_field("cell_column", want.col, got.col);
            compare_field("cell_char", want.ch, got.ch);
            compare_field("cell_attr", want.attr, got.attr);
            compare_field("cell_style", want.style, got.style);
            compare_field("last_result", want.last, got.last);
        endfunction

    endclass

endpackage

/* tb/sv/tb_mono_text_display_cursor_ctrl_unit.sv */
// Self-checking testbench of the monochrome text cursor controller.
module tb_mono_text_display_cursor_ctrl_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import mtdc_pkg::*;
    import mtdc_screen_model_pkg::*;

    localparam int RANDOM_OPS  = 650;
    localparam int PHASES      = 4;
    // Covers the clear pass plus every transaction at its worst
    // gaps and stalls, many times over.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_TAIL  = 16;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_opcode      = '0;
    logic [14:0] i_mem_address = '0;
    logic [7:0]  i_write_value = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_read_data;
    logic [4:0]  o_cell_row;
    logic [6:0]  o_cell_column;
    logic [7:0]  o_cell_char;
    logic [7:0]  o_cell_attr;
    logic [1:0]  o_cell_style;
    logic        o_last_result;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    mtdc_screen_model screen = new();

    mono_text_display_cursor_ctrl_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_mem_address (i_mem_address),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_read_data   (o_read_data),
        .o_cell_row    (o_cell_row),
        .o_cell_column (o_cell_column),
        .o_cell_char   (o_cell_char),
        .o_cell_attr   (o_cell_attr),
        .o_cell_style  (o_cell_style),
        .o_last_result (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stop a hung run: the block never got back to idle.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("mono_text_display_cursor_ctrl_unit regression: fail");
            $finish;
        end
    end

    // Stall the result channel at random, independent of valid.
    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    // Watch both channels at each edge. Note an accepted input transaction
    // before checking the result so the predictor always sees inputs in order.
    always @(posedge i_clk) begin
        mtdc_answer_t seen;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                screen.take_op(i_opcode, i_mem_address, i_write_value);
            end
            if (o_out_valid && !i_out_stall) begin
                seen.kind  = t_kind'(o_result_kind);
                seen.rd    = o_read_data;
                seen.row   = o_cell_row;
                seen.col   = o_cell_column;
                seen.ch    = o_cell_char;
                seen.attr  = o_cell_attr;
                seen.style = o_cell_style;
                seen.last  = o_last_result;
                screen.match_result(seen);
            end
        end
    end

    // Present one input transaction and hold it until the block takes it.
    // Drop valid for random cycles first when the sender is idling.
    task automatic send_op(logic [2:0] op, logic [14:0] addr, logic [7:0] val);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_mem_address <= addr;
        i_write_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Build one random transaction, weighted toward sequences that set up a
    // visible cursor and then blink it: shape and position writes with sane
    // values, memory accesses on the cursor cell, and frequent ticks.
    task automatic send_random(output bit counted);
        int unsigned pick;
        logic [2:0]  op;
        logic [14:0] addr;
        logic [7:0]  val;
        pick = $urandom_range(0, 99);
        addr = 15'($urandom);
        val  = 8'($urandom);
        if (pick < 34) begin
            op = OP_TICK;
        end else if (pick < 48) begin
            op = OP_INDEX_WR;
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 3))
                    0: val[4:0] = CRTC_CUR_START;
                    1: val[4:0] = CRTC_CUR_END;
                    2: val[4:0] = CRTC_POS_HI;
                    default: val[4:0] = CRTC_POS_LO;
                endcase
            end
        end else if (pick < 66) begin
            op = OP_DATA_WR;
            if ($urandom_range(0, 2) != 0) begin
                if (screen.crtc_idx == CRTC_CUR_START) begin
                    val[4:0] = 5'($urandom_range(0, 13));
                end else if (screen.crtc_idx == CRTC_CUR_END) begin
                    val[4:0] = 5'($urandom_range(screen.start_ln, 15));
                end else if (screen.crtc_idx == CRTC_POS_HI) begin
                    // keep the high nibble low so the cursor mostly lands on screen
                    val[3] = 1'b0;
                end
            end
        end else if (pick < 71) begin
            op = OP_DATA_RD;
        end else if (pick < 76) begin
            op = OP_STATUS_RD;
        end else if (pick < 98) begin
            op = (pick < 88) ? OP_MEM_WR : OP_MEM_RD;
            if ($urandom_range(0, 1) != 0) begin
                addr[11:0] = {screen.cur_pos[10:0], 1'($urandom_range(0, 1))};
            end
        end else begin
            op = OP_UNUSED;
        end
        send_op(op, addr, val);
        counted = (op != OP_UNUSED);
    endtask

    initial begin
        int sent;
        bit counted;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Status bits 0 and 3 flip on each read.
        send_op(OP_STATUS_RD, 15'h0000, 8'h00);
        send_op(OP_STATUS_RD, 15'h7fff, 8'hff);
        // An unknown register drops writes and reads back all ones.
        send_op(OP_INDEX_WR, 15'h0000, 8'hff);
        send_op(OP_DATA_WR, 15'h0000, 8'h5a);
        send_op(OP_DATA_RD, 15'h0000, 8'h00);
        // The spare opcode does nothing and answers nothing.
        send_op(OP_UNUSED, 15'h7fff, 8'hff);
        // Full block cursor: start line 0, end line 13.
        send_op(OP_INDEX_WR, 15'h0000, {3'b000, CRTC_CUR_START});
        send_op(OP_DATA_WR, 15'h0000, 8'h00);
        send_op(OP_INDEX_WR, 15'h0000, {3'b111, CRTC_CUR_END});
        send_op(OP_DATA_WR, 15'h0000, 8'h0d);
        // Park the cursor on the last on-screen cell and read it back.
        send_op(OP_INDEX_WR, 15'h0000, {3'b000, CRTC_POS_HI});
        send_op(OP_DATA_WR, 15'h0000, 8'hf7);
        send_op(OP_DATA_RD, 15'h0000, 8'h00);
        send_op(OP_INDEX_WR, 15'h0000, {3'b000, CRTC_POS_LO});
        send_op(OP_DATA_WR, 15'h0000, 8'hcf);
        send_op(OP_DATA_RD, 15'h0000, 8'h00);
        // Fill that cell through the top mirror of the window, read it below.
        send_op(OP_MEM_WR, 15'h7f9e, 8'h41);
        send_op(OP_MEM_WR, 15'h7f9f, ATTR_REVERSE);
        send_op(OP_MEM_RD, 15'h0f9f, 8'h00);
        // Blink into the visible half: the eighth tick draws.
        repeat (8) send_op(OP_TICK, 15'($urandom), 8'($urandom));
        // Move the cursor: the next tick restores the old cell, then draws.
        send_op(OP_DATA_WR, 15'h0000, 8'h00);
        send_op(OP_TICK, 15'h0000, 8'h00);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            sent = 0;
            while (sent < RANDOM_OPS / PHASES) begin
                send_random(counted);
                if (counted) sent++;
            end
        end

        // Release the channel and let everything owed come out.
        i_in_valid <= 1'b0;
        stall_pct = 0;
        while (screen.answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (screen.mismatches == 0 && screen.answers.size() == 0) begin
            $display("mono_text_display_cursor_ctrl_unit regression: pass");
        end else begin
            $display("mono_text_display_cursor_ctrl_unit regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/mtdc_pkg.sv
hdl/mtdc_text_mem.sv
hdl/mtdc_datapath.sv
hdl/mtdc_ctrl.sv
hdl/mono_text_display_cursor_ctrl_unit.sv
tb/sv/mtdc_screen_model_pkg.sv
tb/sv/tb_mono_text_display_cursor_ctrl_unit.sv
